### sv/tts_pkg.sv
// Shared types, sequencer phase codes and helpers for the tilt-to-servo smoother.
package tts_pkg;

  localparam int MOTOR_COUNT = 3;

  localparam logic [8:0]  DT_DEFAULT  = 9'd20;
  localparam logic [31:0] DT_LIMIT    = 32'd500;
  // 4096000 = 2^15 * 125; ceil(2^34 / 125) is exact for dividends below 2^27
  localparam logic [27:0] INTEG_RECIP = 28'd137438954;
  localparam logic [31:0] STEP_HIGH   = 32'd195;
  localparam logic [31:0] STEP_LOW    = 32'd5;
  localparam logic [23:0] POS_TOP     = 24'd25600;
  localparam logic [7:0]  SERVO_TOP   = 8'd200;

  // register indexes
  localparam logic [2:0] REG_DEAD_BAND   = 3'd0;
  localparam logic [2:0] REG_GAIN        = 3'd1;
  localparam logic [2:0] REG_INV_TAU     = 3'd2;
  localparam logic [2:0] REG_JITTER_STEP = 3'd3;
  localparam logic [2:0] REG_IDLE_LIMIT  = 3'd4;

  // sequencer phases
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL1     = 4'd1;
  localparam logic [3:0] S_MUL2     = 4'd2;
  localparam logic [3:0] S_RECIP    = 4'd3;
  localparam logic [3:0] S_INTEG    = 4'd4;
  localparam logic [3:0] S_FM1      = 4'd5;
  localparam logic [3:0] S_FM2      = 4'd6;
  localparam logic [3:0] S_FILT     = 4'd7;
  localparam logic [3:0] S_COPY     = 4'd8;
  localparam logic [3:0] S_HOLD     = 4'd9;
  localparam logic [3:0] S_DIV_GO   = 4'd10;
  localparam logic [3:0] S_DIV_WAIT = 4'd11;
  localparam logic [3:0] S_CLAMP    = 4'd12;
  localparam logic [3:0] S_OUT      = 4'd13;

  typedef struct packed {
    logic [3:0]  phase;
    logic [8:0]  dt;
    logic [24:0] weight;
    logic [14:0] dead_band;
    logic [15:0] gain;
    logic [15:0] step;
  } tts_ctrl_t;

  typedef struct packed {
    logic       moved;
    logic       busy;
    logic [7:0] servo;
  } tts_stat_t;

  function automatic logic [23:0] sat24(input logic signed [35:0] v);
    logic [23:0] r;
    if (v > 36'sd8388607) r = 24'h7fffff;
    else if (v < -36'sd8388608) r = 24'h800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

### sv/tts_if.sv
// Sample and servo command channel interfaces.
interface tts_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tilt_base;
  logic signed [15:0] tilt_height;
  logic [31:0]        now_ms;
  logic               hold;
  modport source (output valid, tilt_base, tilt_height, now_ms, hold, input ready);
  modport sink (input valid, tilt_base, tilt_height, now_ms, hold, output ready);
endinterface

interface tts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] servo_base;
  logic [7:0] servo_height;
  logic [7:0] servo_third;
  logic       moving;
  modport source (output valid, servo_base, servo_height, servo_third, moving, input ready);
  modport sink (input valid, servo_base, servo_height, servo_third, moving, output ready);
endinterface

### sv/tts_div.sv
// Restoring serial divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
module tts_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [15:0] rem;
  logic [31:0] quo;
  logic [15:0] dsr;
  logic [4:0]  cnt;
  logic [16:0] shifted;
  logic [16:0] trial;
  logic        ge;

  assign shifted  = {rem, quo[31]};
  assign trial    = shifted - {1'b0, dsr};
  assign ge       = shifted >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= 16'd0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? trial[15:0] : shifted[15:0];
      quo <= {quo[30:0], ge};
    end
  end

endmodule

### sv/tts_lane.sv
// One motor lane: integrator, exponential filter, jitter hold and step quantizer.
module tts_lane (
  input  logic               clk,
  input  logic               rst,
  input  tts_pkg::tts_ctrl_t ctrl,
  input  logic signed [15:0] tilt,
  input  logic               copy_en,
  input  logic [23:0]        copy_pos,
  output logic [23:0]        filt_pos,
  output tts_pkg::tts_stat_t stat
);

  logic [23:0] integ, filt, held;
  logic        act, neg;
  logic [16:0] mag;
  logic [32:0] p1;
  logic [26:0] dvd;
  logic [54:0] rp;
  logic [24:0] fmag;
  logic        fneg;
  logic [37:0] pp;
  logic [49:0] acc;
  logic [7:0]  servo;

  logic signed [16:0] t17, db17;
  logic signed [16:0] exc;
  logic signed [24:0] fdiff, hdiff;
  logic [24:0]        fdmag;
  logic [24:0]        hmag;
  logic [41:0]        p2;
  logic               div_start, div_busy;
  logic [31:0]        div_q, dividend;
  logic [15:0]        divisor;
  logic signed [35:0] isum, fsum;
  logic [35:0]        q36, inc36;
  logic               hi_clamp, lo_clamp;

  assign t17   = {tilt[15], tilt};
  assign db17  = {2'b00, ctrl.dead_band};
  assign exc   = (t17 > db17) ? (t17 - db17) : (t17 + db17);
  assign p2    = p1 * {33'd0, ctrl.dt};
  assign fdiff = {integ[23], integ} - {filt[23], filt};
  assign fdmag = fdiff[24] ? -fdiff : fdiff;
  assign hdiff = {filt[23], filt} - {held[23], held};
  assign hmag  = hdiff[24] ? -hdiff : hdiff;

  assign div_start = (ctrl.phase == tts_pkg::S_DIV_GO);
  assign dividend  = held[23] ? 32'd0 : {8'd0, held};
  assign divisor   = ctrl.step;

  tts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign q36   = {15'd0, rp[54:34]};
  assign isum  = $signed({{12{integ[23]}}, integ}) + (neg ? -$signed(q36) : $signed(q36));
  assign inc36 = {2'b00, acc[49:16]};
  assign fsum  = $signed({{12{filt[23]}}, filt}) + (fneg ? -$signed(inc36) : $signed(inc36));

  assign hi_clamp = !held[23] && (div_q >= tts_pkg::STEP_HIGH);
  assign lo_clamp = held[23] || (div_q <= tts_pkg::STEP_LOW);

  // datapath registers; the divide by 4096000 is a shift by 15 and a reciprocal multiply
  always_ff @(posedge clk) begin
    case (ctrl.phase)
      tts_pkg::S_MUL1:  p1 <= {16'd0, mag} * {17'd0, ctrl.gain};
      tts_pkg::S_MUL2:  dvd <= p2[41:15];
      tts_pkg::S_RECIP: rp <= {28'd0, dvd} * {27'd0, tts_pkg::INTEG_RECIP};
      tts_pkg::S_FM1: begin
        fneg <= fdiff[24];
        fmag <= fdmag;
        pp   <= {13'd0, ctrl.weight} * {25'd0, fdmag[12:0]};
      end
      default: ;
    endcase
  end

  // magnitude of the tilt beyond the dead band
  always_ff @(posedge clk) begin
    if (ctrl.phase == tts_pkg::S_IDLE) begin
      act <= (t17 > db17) || (t17 < -db17);
      neg <= exc[16];
      mag <= exc[16] ? -exc : exc;
    end
  end

  // low 13 bits of the difference first, high part added on the second pass
  always_ff @(posedge clk) begin
    if (ctrl.phase == tts_pkg::S_FM2)
      acc <= {12'd0, pp}
             + ({12'd0, {13'd0, ctrl.weight} * {26'd0, fmag[24:13]}} << 13);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= 24'd0;
      filt  <= 24'd0;
      held  <= 24'd0;
      servo <= 8'd0;
    end else begin
      case (ctrl.phase)
        tts_pkg::S_INTEG: if (act) integ <= tts_pkg::sat24(isum);
        tts_pkg::S_FILT:  filt <= tts_pkg::sat24(fsum);
        tts_pkg::S_COPY:  if (copy_en) filt <= copy_pos;
        tts_pkg::S_HOLD:  if (hmag >= {9'd0, ctrl.step}) held <= filt;
        tts_pkg::S_CLAMP: begin
          if (hi_clamp) begin
            integ <= tts_pkg::POS_TOP;
            filt  <= tts_pkg::POS_TOP;
            held  <= tts_pkg::POS_TOP;
            servo <= tts_pkg::SERVO_TOP;
          end else if (lo_clamp) begin
            integ <= 24'd0;
            filt  <= 24'd0;
            held  <= 24'd0;
            servo <= 8'd0;
          end else begin
            servo <= div_q[7:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign filt_pos    = filt;
  assign stat.moved  = act;
  assign stat.busy   = div_busy;
  assign stat.servo  = servo;

endmodule

### sv/tilt_to_servo_smoother.sv
// Tilt-to-servo smoother top level: APB registers, sequencer, three lanes, merge.
// An accepted sample runs through the multiply, reciprocal, integrate, filter,
// copy, hold, divide, clamp and output phases, mostly in the serial division of
// the held position by the step size. A new sample is taken only once the last
// result is registered for output; a held sample is absorbed in the idle phase.
// Reset (rst, synchronous) clears all positions, time, idle count and the
// moving flag and loads the register defaults.
module tilt_to_servo_smoother (
  input  logic        clk,
  input  logic        rst,
  tts_in_if.sink      sample,
  tts_out_if.source   servo,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [14:0] dead_band;
  logic [15:0] gain, inv_tau, jitter_step;
  logic [7:0]  idle_limit, idle_count, idle_count_next;
  logic        moving_flag;
  logic [31:0] last_time;
  logic [3:0]  state, state_next;
  logic [8:0]  dt;
  logic [24:0] weight;
  logic        out_valid;
  logic [7:0]  out_base, out_height, out_third;
  logic        out_moving;

  logic [31:0] dt_raw;
  logic        acc_in, wr;
  tts_pkg::tts_ctrl_t ctrl;
  tts_pkg::tts_stat_t st0, st1, st2;
  logic [23:0] filt0, filt1, filt2;
  logic        any_moved;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band   <= 15'd410;
      gain        <= 16'd256;
      inv_tau     <= 16'd655;
      jitter_step <= 16'd128;
      idle_limit  <= 8'd10;
    end else if (wr) begin
      case (paddr[4:2])
        tts_pkg::REG_DEAD_BAND:   dead_band   <= pwdata[14:0];
        tts_pkg::REG_GAIN:        gain        <= pwdata[15:0];
        tts_pkg::REG_INV_TAU:     inv_tau     <= pwdata[15:0];
        tts_pkg::REG_JITTER_STEP: jitter_step <= pwdata[15:0];
        tts_pkg::REG_IDLE_LIMIT:  idle_limit  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      tts_pkg::REG_DEAD_BAND:   prdata = {17'd0, dead_band};
      tts_pkg::REG_GAIN:        prdata = {16'd0, gain};
      tts_pkg::REG_INV_TAU:     prdata = {16'd0, inv_tau};
      tts_pkg::REG_JITTER_STEP: prdata = {16'd0, jitter_step};
      tts_pkg::REG_IDLE_LIMIT:  prdata = {24'd0, idle_limit};
      default:                  prdata = 32'd0;
    endcase
  end

  assign sample.ready = (state == tts_pkg::S_IDLE);
  assign acc_in       = sample.valid && sample.ready;
  assign dt_raw       = sample.now_ms - last_time;

  always_comb begin
    state_next = state;
    case (state)
      tts_pkg::S_IDLE:     if (acc_in && !sample.hold) state_next = tts_pkg::S_MUL1;
      tts_pkg::S_MUL1:     state_next = tts_pkg::S_MUL2;
      tts_pkg::S_MUL2:     state_next = tts_pkg::S_RECIP;
      tts_pkg::S_RECIP:    state_next = tts_pkg::S_INTEG;
      tts_pkg::S_INTEG:    state_next = tts_pkg::S_FM1;
      tts_pkg::S_FM1:      state_next = tts_pkg::S_FM2;
      tts_pkg::S_FM2:      state_next = tts_pkg::S_FILT;
      tts_pkg::S_FILT:     state_next = tts_pkg::S_COPY;
      tts_pkg::S_COPY:     state_next = tts_pkg::S_HOLD;
      tts_pkg::S_HOLD:     state_next = tts_pkg::S_DIV_GO;
      tts_pkg::S_DIV_GO:   state_next = tts_pkg::S_DIV_WAIT;
      tts_pkg::S_DIV_WAIT: if (!st0.busy) state_next = tts_pkg::S_CLAMP;
      tts_pkg::S_CLAMP:    state_next = tts_pkg::S_OUT;
      tts_pkg::S_OUT:      if (!out_valid || servo.ready) state_next = tts_pkg::S_IDLE;
      default:             state_next = tts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tts_pkg::S_IDLE;
      last_time <= 32'd0;
    end else begin
      state <= state_next;
      if (acc_in && !sample.hold) last_time <= sample.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && !sample.hold) begin
      dt <= (dt_raw == 32'd0 || dt_raw >= tts_pkg::DT_LIMIT) ? tts_pkg::DT_DEFAULT
                                                             : dt_raw[8:0];
    end
    if (state == tts_pkg::S_MUL1) weight <= dt * inv_tau;
  end

  assign ctrl.phase     = state;
  assign ctrl.dt        = dt;
  assign ctrl.weight    = weight;
  assign ctrl.dead_band = dead_band;
  assign ctrl.gain      = gain;
  assign ctrl.step      = (jitter_step == 16'd0) ? 16'd1 : jitter_step;

  // lanes latch the tilt beyond the dead band at the accepting edge
  tts_lane u_lane_base (
    .clk(clk), .rst(rst), .ctrl(ctrl), .tilt(sample.tilt_base),
    .copy_en(1'b0), .copy_pos(24'd0), .filt_pos(filt0), .stat(st0)
  );

  tts_lane u_lane_height (
    .clk(clk), .rst(rst), .ctrl(ctrl), .tilt(sample.tilt_height),
    .copy_en(1'b0), .copy_pos(24'd0), .filt_pos(filt1), .stat(st1)
  );

  // third motor never integrates; its filter copies the height lane
  tts_lane u_lane_third (
    .clk(clk), .rst(rst), .ctrl(ctrl), .tilt(16'sd0),
    .copy_en(1'b1), .copy_pos(filt1), .filt_pos(filt2), .stat(st2)
  );

  // merge: idle tracking and result register
  assign any_moved       = st0.moved || st1.moved || st2.moved;
  assign idle_count_next = (idle_count == 8'hff) ? idle_count : idle_count + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count  <= 8'd0;
      moving_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (state == tts_pkg::S_INTEG) begin
        if (any_moved) begin
          idle_count  <= 8'd0;
          moving_flag <= 1'b1;
        end else begin
          idle_count <= idle_count_next;
          if (idle_count_next >= idle_limit) moving_flag <= 1'b0;
        end
      end
      if (state == tts_pkg::S_OUT && (!out_valid || servo.ready)) out_valid <= 1'b1;
      else if (servo.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tts_pkg::S_OUT && (!out_valid || servo.ready)) begin
      out_base   <= st0.servo;
      out_height <= st1.servo;
      out_third  <= st2.servo;
      out_moving <= moving_flag;
    end
  end

  assign servo.valid        = out_valid;
  assign servo.servo_base   = out_base;
  assign servo.servo_height = out_height;
  assign servo.servo_third  = out_third;
  assign servo.moving       = out_moving;

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (st0.busy == st1.busy) && (st1.busy == st2.busy))
    else $error("lane dividers out of step");

  a_hold_absorbed: assert property (@(posedge clk) disable iff (rst)
    (acc_in && sample.hold) |=> (state == tts_pkg::S_IDLE))
    else $error("held sample started work");

  a_servo_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_base <= 8'd200 && out_height <= 8'd200 && out_third <= 8'd200))
    else $error("servo step out of range");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == tts_pkg::S_OUT))
    else $error("result shown outside output phase");

  a_third_follows: assert property (@(posedge clk) disable iff (rst)
    (state == tts_pkg::S_HOLD) |-> (filt2 == filt1))
    else $error("third filter not following height");

  a_top_clamp_resets: assert property (@(posedge clk) disable iff (rst)
    (state == tts_pkg::S_OUT && st0.servo == tts_pkg::SERVO_TOP)
      |-> (filt0 == tts_pkg::POS_TOP))
    else $error("high clamp left filter state");

endmodule

### tb/tb_tilt_to_servo_smoother.sv
// Testbench for the tilt-to-servo smoother: random samples, register phases, scoreboard.
module tb_tilt_to_servo_smoother;

  typedef struct {
    logic signed [15:0] tb;
    logic signed [15:0] th;
    logic [31:0]        now;
    logic               hold;
    int                 gap;
  } sample_t;

  typedef struct {
    logic [7:0] sb;
    logic [7:0] sh;
    logic [7:0] st;
    logic       mv;
  } cmd_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tts_in_if  smp();
  tts_out_if srv();

  tilt_to_servo_smoother dut (
    .clk(clk), .rst(rst), .sample(smp), .servo(srv),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor state
  longint m_db, m_gain, m_tau, m_jit, m_idle;
  longint m_last;
  longint m_integ[3], m_filt[3], m_held[3];
  longint m_idle_cnt;
  bit     m_moving;

  sample_t pending_q[$];
  cmd_t    expected_q[$];
  int      errors = 0;
  int      n_results = 0;
  int      n_sent = 0;

  function automatic longint sat_pos(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint tdiv(longint num, longint den);
    longint q;
    q = (num < 0 ? -num : num) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic bit axis_integrate(int idx, longint tilt, longint dt);
    longint ex;
    if (tilt > m_db) ex = tilt - m_db;
    else if (tilt < -m_db) ex = tilt + m_db;
    else return 0;
    m_integ[idx] = sat_pos(m_integ[idx] + tdiv(ex * m_gain * dt, 4096000));
    return 1;
  endfunction

  function automatic void predict_servo(sample_t s);
    longint dt, w, stp, d, q;
    bit mb, mh;
    cmd_t c;
    logic [7:0] sv[3];
    if (s.hold) return;
    dt = (longint'(s.now) - m_last) & 64'hffff_ffff;
    m_last = s.now;
    if (dt == 0 || dt >= 500) dt = 20;
    mb = axis_integrate(0, s.tb, dt);
    mh = axis_integrate(1, s.th, dt);
    if (!mb && !mh) begin
      if (m_idle_cnt < 255) m_idle_cnt++;
      if (m_idle_cnt >= m_idle) m_moving = 0;
    end else begin
      m_idle_cnt = 0;
      m_moving = 1;
    end
    w = dt * m_tau;
    for (int i = 0; i < 2; i++)
      m_filt[i] = sat_pos(m_filt[i] + tdiv(w * (m_integ[i] - m_filt[i]), 65536));
    m_filt[2] = m_filt[1];
    stp = (m_jit == 0) ? 1 : m_jit;
    for (int i = 0; i < 3; i++) begin
      d = m_filt[i] - m_held[i];
      if (d >= stp || d <= -stp) m_held[i] = m_filt[i];
    end
    for (int i = 0; i < 3; i++) begin
      q = tdiv(m_held[i], stp);
      if (m_held[i] >= 0 && q >= 195) begin
        m_integ[i] = 25600; m_filt[i] = 25600; m_held[i] = 25600;
        sv[i] = tts_pkg::SERVO_TOP;
      end else if (m_held[i] < 0 || q <= 5) begin
        m_integ[i] = 0; m_filt[i] = 0; m_held[i] = 0;
        sv[i] = 8'd0;
      end else begin
        sv[i] = q[7:0];
      end
    end
    c.sb = sv[0]; c.sh = sv[1]; c.st = sv[2]; c.mv = m_moving;
    expected_q.push_back(c);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      smp.valid <= 0;
      smp.tilt_base <= '0; smp.tilt_height <= '0; smp.now_ms <= '0; smp.hold <= 0;
      gap_left <= 0;
    end else if (smp.valid && !smp.ready) begin
    end else begin
      if (smp.valid) begin
        sample_t acc;
        acc.tb = smp.tilt_base; acc.th = smp.tilt_height;
        acc.now = smp.now_ms; acc.hold = smp.hold; acc.gap = 0;
        predict_servo(acc);
        n_sent++;
      end
      if (gap_left > 0) begin
        smp.valid <= 0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0) begin
        sample_t s;
        s = pending_q.pop_front();
        if (s.gap > 0 && !smp.valid) begin
          pending_q.push_front(s);
          pending_q[0].gap = 0;
          smp.valid <= 0;
          gap_left <= s.gap - 1;
        end else begin
          smp.valid <= 1;
          smp.tilt_base <= s.tb; smp.tilt_height <= s.th;
          smp.now_ms <= s.now; smp.hold <= s.hold;
          gap_left <= s.gap;
        end
      end else begin
        smp.valid <= 0;
      end
    end
  end

  // monitor
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      srv.ready <= 0;
      stall_left <= 0;
    end else begin
      if (srv.valid && srv.ready) begin
        if (expected_q.size() == 0) begin
          report("servo beat with none expected", srv.servo_base, -1);
        end else begin
          cmd_t e;
          e = expected_q.pop_front();
          if (srv.servo_base !== e.sb) report("servo_base", srv.servo_base, e.sb);
          if (srv.servo_height !== e.sh) report("servo_height", srv.servo_height, e.sh);
          if (srv.servo_third !== e.st) report("servo_third", srv.servo_third, e.st);
          if (srv.moving !== e.mv) report("moving", srv.moving, e.mv);
        end
        n_results++;
        stall_left <= $urandom_range(0, 7) * ($urandom_range(0, 3) == 0 ? 0 : 1);
        srv.ready <= 0;
      end else if (stall_left > 0) begin
        srv.ready <= 0;
        stall_left <= stall_left - 1;
      end else begin
        srv.ready <= 1;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      tts_pkg::REG_DEAD_BAND:   m_db = val & 32'h7fff;
      tts_pkg::REG_GAIN:        m_gain = val & 32'hffff;
      tts_pkg::REG_INV_TAU:     m_tau = val & 32'hffff;
      tts_pkg::REG_JITTER_STEP: m_jit = val & 32'hffff;
      tts_pkg::REG_IDLE_LIMIT:  m_idle = val & 32'hff;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || smp.valid || expected_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic void add_sample(logic signed [15:0] tb, logic signed [15:0] th,
                                     logic [31:0] now, logic hold);
    sample_t s;
    s.tb = tb; s.th = th; s.now = now; s.hold = hold;
    s.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    pending_q.push_back(s);
  endfunction

  logic [31:0] clock_ms = 0;

  function automatic logic signed [15:0] rand_tilt();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 800) - 400);
      2: return 16'sh7fff;
      3: return -16'sh8000;
      default: return 16'($urandom_range(0, 12000) - 6000);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: clock_ms = $urandom;
        1: clock_ms = clock_ms;
        2: clock_ms = clock_ms + $urandom_range(500, 5000);
        default: clock_ms = clock_ms + $urandom_range(1, 60);
      endcase
      if ($urandom_range(0, 4) == 0) add_sample(16'sd0, 16'sd0, clock_ms, 1'b0);
      else add_sample(rand_tilt(), rand_tilt(), clock_ms, $urandom_range(0, 12) == 0);
    end
  endtask

  initial begin
    m_db = 410; m_gain = 256; m_tau = 655; m_jit = 128; m_idle = 10;
    m_last = 0; m_idle_cnt = 0; m_moving = 0;
    for (int i = 0; i < 3; i++) begin
      m_integ[i] = 0; m_filt[i] = 0; m_held[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 0;
    // directed: field extremes, held samples, dt corner cases, clamps
    add_sample(16'sh7fff, 16'sh7fff, 32'd0, 1'b0);
    add_sample(-16'sh8000, -16'sh8000, 32'd0, 1'b0);
    add_sample(16'sh7fff, -16'sh8000, 32'hffff_ffff, 1'b0);
    add_sample(16'sh7fff, 16'sh7fff, 32'd5, 1'b1);
    add_sample(16'sd410, -16'sd410, 32'd18, 1'b0);
    add_sample(16'sd411, -16'sd411, 32'd517, 1'b0);
    add_sample(16'sd0, 16'sd0, 32'd518, 1'b0);
    add_sample(-16'sd1, 16'sh5555, 32'd1017, 1'b0);
    add_sample(16'shaaaa, 16'sd0, 32'd1516, 1'b0);
    for (int i = 0; i < 12; i++) add_sample(16'sd0, 16'sd0, 32'd2000 + 20 * i, 1'b0);
    add_sample(16'sd20000, 16'sd20000, 32'd3000, 1'b0);
    wait_drained();
    // extremes of registers
    reg_write(tts_pkg::REG_DEAD_BAND, 32'hffff_ffff);
    reg_write(tts_pkg::REG_GAIN, 32'hffff);
    reg_write(tts_pkg::REG_INV_TAU, 32'hffff);
    reg_write(tts_pkg::REG_JITTER_STEP, 32'd1);
    reg_write(tts_pkg::REG_IDLE_LIMIT, 32'd0);
    random_phase(100);
    wait_drained();
    reg_write(tts_pkg::REG_DEAD_BAND, 32'd0);
    reg_write(tts_pkg::REG_JITTER_STEP, 32'd0);
    reg_write(tts_pkg::REG_IDLE_LIMIT, 32'd255);
    reg_write(tts_pkg::REG_INV_TAU, 32'd0);
    reg_write(tts_pkg::REG_GAIN, 32'd0);
    random_phase(100);
    wait_drained();
    reg_write(tts_pkg::REG_JITTER_STEP, 32'hffff);
    reg_write(tts_pkg::REG_GAIN, 32'h1234);
    reg_write(tts_pkg::REG_INV_TAU, 32'd3000);
    random_phase(100);
    wait_drained();
    for (int p = 0; p < 7; p++) begin
      reg_write(tts_pkg::REG_DEAD_BAND, $urandom_range(0, 2000));
      reg_write(tts_pkg::REG_GAIN, $urandom_range(0, 4000));
      reg_write(tts_pkg::REG_INV_TAU, $urandom_range(0, 8000));
      reg_write(tts_pkg::REG_JITTER_STEP, $urandom_range(0, 400));
      reg_write(tts_pkg::REG_IDLE_LIMIT, $urandom_range(0, 20));
      random_phase(100);
      wait_drained();
    end
    $display("covered %0d samples and %0d servo beats over 11 register settings",
             n_sent, n_results);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end
endmodule
